/* rtl/core/pbpa_pkg.sv */
package pbpa_pkg;

  // Pool limits
  localparam int unsigned MaxBlocks   = 1024;
  localparam int unsigned MaxPages    = 16;
  localparam int unsigned HeaderBytes = 8;

  // Field widths
  localparam int unsigned IdxW  = 10;  // block index
  localparam int unsigned CntW  = 11;  // block counts and links, holds MaxBlocks
  localparam int unsigned PageW = 5;   // page count, holds MaxPages
  localparam int unsigned OffW  = 20;  // byte offset
  localparam int unsigned BbW   = 17;  // block size in bytes
  localparam int unsigned CfgW  = 17;  // config write data
  localparam int unsigned CfgAw = 2;   // config register index

  // Empty list marker
  localparam logic [CntW-1:0] NullIdx = CntW'(MaxBlocks);

  // Config register indexes
  localparam logic [CfgAw-1:0] RegDataSize  = 2'd0;
  localparam logic [CfgAw-1:0] RegAlignLog2 = 2'd1;
  localparam logic [CfgAw-1:0] RegPageSize  = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_MEM    = 2'd1,
    STATUS_BAD_CFG   = 2'd2,
    STATUS_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_INIT,    // derive block size, load divider
    ST_DIV,     // blocks-per-page division, one quotient bit a cycle
    ST_IDLE,
    ST_FILL,    // link a new page, one block a cycle
    ST_POP_RD,  // read of the new head in flight
    ST_POP      // head link and offset available
  } state_e;

endpackage

/* rtl/core/paged_block_pool_allocator.sv */
// Fixed-size block pool with a LIFO free list held in a 1024-entry link memory.
// Request channel: a request beat is taken when start_i is high and busy_o is
// low. operation_i selects allocate, free or free-all; block_index_i is used
// by free only. Every request not cut short by a config write gives exactly one
// result beat: done_o is high for one cycle with status_o, given_block_o,
// byte_offset_o and the pool counts. The receiver cannot stall; results are never
// held back. Free, free-all and the unused code answer in the cycle after the
// request. Allocate from a non-empty list answers from ST_POP, which takes the
// registered read of the link and offset memories. Allocate that must add a
// page first sweeps the page into both memories one block per cycle, then
// passes ST_POP_RD and ST_POP. A request can be taken while a result shows.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i, cfg_data_i;
// ready is always high. A write to one of the three registers empties the
// pool and recomputes the block size and blocks per page: busy_o is high
// through the setup state and a 17-step divider, or through the setup state
// only when the page is no bigger than its header. Reset loads an 8-byte
// payload, alignment log2 of 3 and a 4096-byte page, and runs the same
// derivation before the first request.
module paged_block_pool_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        operation_i,
  input  logic [pbpa_pkg::IdxW-1:0]         block_index_i,
  // config
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pbpa_pkg::CfgAw-1:0]        cfg_index_i,
  input  logic [pbpa_pkg::CfgW-1:0]         cfg_data_i,
  // result
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [pbpa_pkg::IdxW-1:0]         given_block_o,
  output logic [pbpa_pkg::OffW-1:0]         byte_offset_o,
  output logic [pbpa_pkg::PageW-1:0]        page_count_o,
  output logic [pbpa_pkg::CntW-1:0]         total_count_o,
  output logic [pbpa_pkg::CntW-1:0]         free_count_o
);

  localparam int unsigned Depth = pbpa_pkg::MaxBlocks;

  // Config registers
  logic [15:0]                 payload_bytes_q;
  logic [3:0]                  align_log2_q;
  logic [16:0]                 page_bytes_q;

  // Control and pool state
  pbpa_pkg::state_e            state_q, state_d;
  logic [pbpa_pkg::CntW-1:0]   head_q, head_d;
  logic [pbpa_pkg::PageW-1:0]  pages_q, pages_d;
  logic [pbpa_pkg::CntW-1:0]   total_q, total_d;
  logic [pbpa_pkg::CntW-1:0]   free_q, free_d;
  logic [pbpa_pkg::OffW-1:0]   page_off_q, page_off_d;
  logic [pbpa_pkg::BbW-1:0]    block_bytes_q, block_bytes_d;
  logic [pbpa_pkg::CntW-1:0]   per_page_q, per_page_d;

  // Divider and page sweep
  logic [16:0]                 rem_q, rem_d;
  logic [16:0]                 quo_q, quo_d;
  logic [4:0]                  div_cnt_q, div_cnt_d;
  logic [pbpa_pkg::CntW-1:0]   fill_cnt_q, fill_cnt_d;
  logic [pbpa_pkg::OffW-1:0]   fill_off_q, fill_off_d;

  // Result register
  logic                        done_q, done_d;
  pbpa_pkg::status_e           status_q, status_d;
  logic [pbpa_pkg::IdxW-1:0]   given_q, given_d;
  logic [pbpa_pkg::OffW-1:0]   offset_q, offset_d;

  // Memories
  logic [pbpa_pkg::CntW-1:0]   link_mem [Depth];
  logic [pbpa_pkg::OffW-1:0]   off_mem  [Depth];
  logic [pbpa_pkg::CntW-1:0]   rd_link_q;
  logic [pbpa_pkg::OffW-1:0]   rd_off_q;
  logic                        link_we, off_we;
  logic [pbpa_pkg::IdxW-1:0]   wr_addr;
  logic [pbpa_pkg::CntW-1:0]   wr_link;
  logic [pbpa_pkg::OffW-1:0]   wr_off;

  // Combinational helpers
  logic                        accept, cfg_we, cfg_hit;
  logic [15:0]                 least;
  logic [17:0]                 align_mask;
  logic [17:0]                 bb_round;
  logic [17:0]                 div_shift, div_diff;
  logic [11:0]                 total_grow;
  logic [pbpa_pkg::CntW-1:0]   fill_addr;
  logic                        fill_last;

  assign accept = start_i && (state_q == pbpa_pkg::ST_IDLE);
  assign cfg_we = cfg_valid_i;  // ready is always high
  // only writes to an existing register touch the pool
  assign cfg_hit = cfg_we && (cfg_index_i == pbpa_pkg::RegDataSize ||
                              cfg_index_i == pbpa_pkg::RegAlignLog2 ||
                              cfg_index_i == pbpa_pkg::RegPageSize);

  // Block size: max(header, data) rounded up to the alignment
  assign least      = (payload_bytes_q > 16'(pbpa_pkg::HeaderBytes)) ?
                      payload_bytes_q : 16'(pbpa_pkg::HeaderBytes);
  assign align_mask = (18'd1 << align_log2_q) - 18'd1;
  assign bb_round   = ({2'b00, least} + align_mask) & ~align_mask;

  // Restoring divider step
  assign div_shift = {rem_q, quo_q[16]};
  assign div_diff  = div_shift - {1'b0, block_bytes_q};

  assign total_grow = {1'b0, total_q} + {1'b0, per_page_q};
  assign fill_addr  = total_q + fill_cnt_q;
  assign fill_last  = (fill_cnt_q == per_page_q - pbpa_pkg::CntW'(1));

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_bytes_q <= 16'd8;
      align_log2_q    <= 4'd3;
      page_bytes_q    <= 17'd4096;
    end else if (cfg_we) begin
      case (cfg_index_i)
        pbpa_pkg::RegDataSize:  payload_bytes_q <= cfg_data_i[15:0];
        pbpa_pkg::RegAlignLog2: align_log2_q    <= cfg_data_i[3:0];
        pbpa_pkg::RegPageSize:  page_bytes_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state, pool update, memory writes and result
  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    pages_d       = pages_q;
    total_d       = total_q;
    free_d        = free_q;
    page_off_d    = page_off_q;
    block_bytes_d = block_bytes_q;
    per_page_d    = per_page_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    div_cnt_d     = div_cnt_q;
    fill_cnt_d    = fill_cnt_q;
    fill_off_d    = fill_off_q;
    done_d        = 1'b0;
    status_d      = status_q;
    given_d       = given_q;
    offset_d      = offset_q;
    link_we       = 1'b0;
    off_we        = 1'b0;
    wr_addr       = fill_addr[pbpa_pkg::IdxW-1:0];
    wr_link       = fill_last ? pbpa_pkg::NullIdx : fill_addr + pbpa_pkg::CntW'(1);
    wr_off        = fill_off_q;

    case (state_q)
      pbpa_pkg::ST_INIT: begin
        block_bytes_d = bb_round[pbpa_pkg::BbW-1:0];
        rem_d         = '0;
        quo_d         = page_bytes_q - 17'(pbpa_pkg::HeaderBytes);
        div_cnt_d     = '0;
        if (page_bytes_q <= 17'(pbpa_pkg::HeaderBytes)) begin
          per_page_d = '0;
          state_d    = pbpa_pkg::ST_IDLE;
        end else begin
          state_d = pbpa_pkg::ST_DIV;
        end
      end

      pbpa_pkg::ST_DIV: begin
        if (!div_diff[17]) begin
          rem_d = div_diff[16:0];
          quo_d = {quo_q[15:0], 1'b1};
        end else begin
          rem_d = div_shift[16:0];
          quo_d = {quo_q[15:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == 5'd16) begin
          // saturate: such a page never fits anyway
          per_page_d = (quo_d > 17'(pbpa_pkg::MaxBlocks)) ?
                       pbpa_pkg::CntW'(pbpa_pkg::MaxBlocks + 1) :
                       quo_d[pbpa_pkg::CntW-1:0];
          state_d    = pbpa_pkg::ST_IDLE;
        end
      end

      pbpa_pkg::ST_IDLE: begin
        if (accept) begin
          given_d  = '0;
          offset_d = '0;
          status_d = pbpa_pkg::STATUS_OK;
          case (pbpa_pkg::op_e'(operation_i))
            pbpa_pkg::OP_ALLOC: begin
              if (head_q != pbpa_pkg::NullIdx) begin
                // link read of head_q issued at this edge
                state_d = pbpa_pkg::ST_POP;
              end else if (per_page_q == '0) begin
                status_d = pbpa_pkg::STATUS_BAD_CFG;
                done_d   = 1'b1;
              end else if (pages_q >= pbpa_pkg::PageW'(pbpa_pkg::MaxPages) ||
                           total_grow > 12'(pbpa_pkg::MaxBlocks)) begin
                status_d = pbpa_pkg::STATUS_NO_MEM;
                done_d   = 1'b1;
              end else begin
                fill_cnt_d = '0;
                fill_off_d = page_off_q + pbpa_pkg::OffW'(pbpa_pkg::HeaderBytes);
                state_d    = pbpa_pkg::ST_FILL;
              end
            end
            pbpa_pkg::OP_FREE: begin
              if ({1'b0, block_index_i} >= total_q) begin
                status_d = pbpa_pkg::STATUS_BAD_INDEX;
              end else begin
                link_we = 1'b1;
                wr_addr = block_index_i;
                wr_link = head_q;
                head_d  = {1'b0, block_index_i};
                free_d  = free_q + pbpa_pkg::CntW'(1);
              end
              done_d = 1'b1;
            end
            pbpa_pkg::OP_FREE_ALL: begin
              head_d     = pbpa_pkg::NullIdx;
              pages_d    = '0;
              total_d    = '0;
              free_d     = '0;
              page_off_d = '0;
              done_d     = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Chain the new page in ascending order and record slot offsets
      pbpa_pkg::ST_FILL: begin
        link_we    = 1'b1;
        off_we     = 1'b1;
        fill_cnt_d = fill_cnt_q + pbpa_pkg::CntW'(1);
        fill_off_d = fill_off_q + pbpa_pkg::OffW'(block_bytes_q);
        if (fill_last) begin
          head_d     = total_q;
          pages_d    = pages_q + pbpa_pkg::PageW'(1);
          total_d    = total_grow[pbpa_pkg::CntW-1:0];
          free_d     = free_q + per_page_q;
          page_off_d = page_off_q + pbpa_pkg::OffW'(page_bytes_q);
          state_d    = pbpa_pkg::ST_POP_RD;
        end
      end

      pbpa_pkg::ST_POP_RD: begin
        state_d = pbpa_pkg::ST_POP;
      end

      // Pop the head using the registered memory read
      pbpa_pkg::ST_POP: begin
        given_d  = head_q[pbpa_pkg::IdxW-1:0];
        offset_d = rd_off_q;
        status_d = pbpa_pkg::STATUS_OK;
        head_d   = rd_link_q;
        free_d   = free_q - pbpa_pkg::CntW'(1);
        done_d   = 1'b1;
        state_d  = pbpa_pkg::ST_IDLE;
      end

      default: begin
        state_d = pbpa_pkg::ST_INIT;
      end
    endcase

    // A config write empties the pool and rederives the sizes
    if (cfg_hit) begin
      head_d     = pbpa_pkg::NullIdx;
      pages_d    = '0;
      total_d    = '0;
      free_d     = '0;
      page_off_d = '0;
      state_d    = pbpa_pkg::ST_INIT;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pbpa_pkg::ST_INIT;
      head_q     <= pbpa_pkg::NullIdx;
      pages_q    <= '0;
      total_q    <= '0;
      free_q     <= '0;
      page_off_q <= '0;
      per_page_q <= '0;
      div_cnt_q  <= '0;
      fill_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      pages_q    <= pages_d;
      total_q    <= total_d;
      free_q     <= free_d;
      page_off_q <= page_off_d;
      per_page_q <= per_page_d;
      div_cnt_q  <= div_cnt_d;
      fill_cnt_q <= fill_cnt_d;
      done_q     <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    block_bytes_q <= block_bytes_d;
    rem_q         <= rem_d;
    quo_q         <= quo_d;
    fill_off_q    <= fill_off_d;
    status_q      <= status_d;
    given_q       <= given_d;
    offset_q      <= offset_d;
  end

  // Link memory: one write port, head read every cycle
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
    rd_link_q <= link_mem[head_q[pbpa_pkg::IdxW-1:0]];
  end

  // Offset memory: written by the page sweep only
  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[wr_addr] <= wr_off;
    end
    rd_off_q <= off_mem[head_q[pbpa_pkg::IdxW-1:0]];
  end

  // Outputs; counts already hold the post-request values during done_o
  assign busy_o        = (state_q != pbpa_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign given_block_o = given_q;
  assign byte_offset_o = offset_q;
  assign page_count_o  = pages_q;
  assign total_count_o = total_q;
  assign free_count_o  = free_q;

endmodule

/* rtl/core/pbpa_checker.sv */
module pbpa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              done_o,
  input logic [1:0]                        status_o,
  input logic [pbpa_pkg::IdxW-1:0]         given_block_o,
  input logic [pbpa_pkg::OffW-1:0]         byte_offset_o,
  input logic [pbpa_pkg::PageW-1:0]        page_count_o,
  input logic [pbpa_pkg::CntW-1:0]         total_count_o
);

  // Every taken request is either answered or still being worked on
  a_req_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("request dropped");

  // Failed results carry no block
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != pbpa_pkg::STATUS_OK) |->
      (given_block_o == '0 && byte_offset_o == '0))
    else $error("failed result carries a block");

  // Pool never grows past its limits
  a_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (page_count_o <= pbpa_pkg::PageW'(pbpa_pkg::MaxPages) &&
                total_count_o <= pbpa_pkg::CntW'(pbpa_pkg::MaxBlocks)))
    else $error("pool beyond limits");

  // A handed-out block lies inside the pool
  a_given_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == pbpa_pkg::STATUS_OK && byte_offset_o != '0) |->
      ({1'b0, given_block_o} < total_count_o))
    else $error("block outside pool");

endmodule

bind paged_block_pool_allocator pbpa_checker u_pbpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .status_o      (status_o),
  .given_block_o (given_block_o),
  .byte_offset_o (byte_offset_o),
  .page_count_o  (page_count_o),
  .total_count_o (total_count_o)
);
